// File: rtl/core/srecord_to_binary_converter_macros.svh
// Assertion helpers shared by the converter RTL.
`ifndef SRECORD_TO_BINARY_CONVERTER_MACROS_SVH
`define SRECORD_TO_BINARY_CONVERTER_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SRTB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("srtb: assertion failed");

// Same-cycle implication.
`define SRTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srtb: implication failed");

`endif

// File: rtl/core/srtb_pkg.sv
`default_nettype none

package srtb_pkg;

	// result kinds
	localparam logic [2:0] KIND_BYTE     = 3'd0;
	localparam logic [2:0] KIND_ZERO_RUN = 3'd1;
	localparam logic [2:0] KIND_DONE     = 3'd2;
	localparam logic [2:0] KIND_FMT_ERR  = 3'd3;
	localparam logic [2:0] KIND_OVERLAP  = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_PREFIX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_PREFIX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_GAPS      = 2'd2;

	// characters
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [15:0] run_length;
	} result_t;

	// up to two results caused by one character
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} entry_t;

endpackage

`default_nettype wire

// File: rtl/core/srtb_front.sv
`default_nettype none
`include "srecord_to_binary_converter_macros.svh"

module srtb_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [7:0]                       char_code,
	input  wire logic                             end_of_file,
	input  wire logic                             cfg_we,
	input  wire logic [srtb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic                             cfg_data,
	output logic                                  push,
	output srtb_pkg::entry_t                      push_entry
);

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_TYPE    = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_TERM    = 3'd4;
	localparam logic [2:0] PH_BODY_HI = 3'd5;
	localparam logic [2:0] PH_BODY_LO = 3'd6;

	localparam logic [1:0] RT_S0 = 2'd0;
	localparam logic [1:0] RT_S1 = 2'd1;
	localparam logic [1:0] RT_S9 = 2'd2;

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = c - srtb_pkg::CH_ZERO;
		if (c > srtb_pkg::CH_NINE)
			v = v - 8'd7;
		return v;
	endfunction

	function automatic srtb_pkg::result_t mk_res(input logic [2:0] k, input logic [7:0] b,
			input logic [15:0] run);
		srtb_pkg::result_t r;
		r.kind       = k;
		r.value      = b;
		r.run_length = run;
		return r;
	endfunction

	logic length_prefix_on_q, address_prefix_on_q, fill_gaps_on_q;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  first_q, first_d;
	logic [1:0]  rtype_q, rtype_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  pcnt_q, pcnt_d;
	logic [7:0]  hi_q, hi_d;
	logic [16:0] exp_q, exp_d;
	logic        seen_q, seen_d;
	logic        halted_q, halted_d;

	logic [7:0]  v_hi, pair_b, pnext, data_cnt;
	logic [15:0] addr, gap;
	logic [16:0] exp_new;
	logic        overlap;
	logic        err, complete;
	logic        have_a, have_b;
	srtb_pkg::result_t res_a, res_b;
	srtb_pkg::entry_t  ent;

	assign v_hi     = hex_val(first_q);
	assign pair_b   = {v_hi[3:0], 4'b0000} | hex_val(char_code);
	assign pnext    = pcnt_q + 8'd1;
	assign addr     = {hi_q, pair_b};
	assign data_cnt = (len_q >= 8'd3) ? len_q - 8'd3 : 8'd0;
	assign exp_new  = {1'b0, addr} + {9'd0, data_cnt};
	assign overlap  = exp_q > {1'b0, addr};
	assign gap      = addr - exp_q[15:0];

	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		rtype_d  = rtype_q;
		len_d    = len_q;
		pcnt_d   = pcnt_q;
		hi_d     = hi_q;
		exp_d    = exp_q;
		seen_d   = seen_q;
		halted_d = halted_q;
		err      = 1'b0;
		complete = 1'b0;
		have_a   = 1'b0;
		have_b   = 1'b0;
		res_a    = '0;
		res_b    = '0;
		case (phase_q)
			PH_TYPE: begin
				if (char_code == srtb_pkg::CH_ZERO)
					rtype_d = RT_S0;
				else if (char_code == srtb_pkg::CH_ONE)
					rtype_d = RT_S1;
				else if (char_code == srtb_pkg::CH_NINE)
					rtype_d = RT_S9;
				else
					err = 1'b1;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI, PH_BODY_HI: begin
				first_d = char_code;
				phase_d = phase_q + 3'd1;
			end
			PH_LEN_LO: begin
				len_d  = pair_b;
				pcnt_d = '0;
				hi_d   = '0;
				if (rtype_q == RT_S1 && length_prefix_on_q) begin
					have_a = 1'b1;
					res_a  = mk_res(srtb_pkg::KIND_BYTE,
						address_prefix_on_q ? pair_b : pair_b - 8'd2, 16'd0);
				end
				phase_d = (pair_b == 8'd0) ? PH_TERM : PH_BODY_HI;
			end
			PH_BODY_LO: begin
				pcnt_d = pnext;
				if (rtype_q == RT_S1) begin
					if (pnext == 8'd1) begin
						hi_d   = pair_b;
						have_a = address_prefix_on_q;
						res_a  = mk_res(srtb_pkg::KIND_BYTE, pair_b, 16'd0);
					end else if (pnext == 8'd2) begin
						have_a = address_prefix_on_q;
						res_a  = mk_res(srtb_pkg::KIND_BYTE, pair_b, 16'd0);
						if (fill_gaps_on_q) begin
							if (!seen_q) begin
								seen_d = 1'b1;
								exp_d  = exp_new;
							end else if (overlap) begin
								have_b   = 1'b1;
								res_b    = mk_res(srtb_pkg::KIND_OVERLAP, 8'd0, 16'd0);
								halted_d = 1'b1;
							end else begin
								have_b = (gap != 16'd0);
								res_b  = mk_res(srtb_pkg::KIND_ZERO_RUN, 8'd0, gap);
								exp_d  = exp_new;
							end
						end
					end else if (pnext < len_q) begin
						have_a = 1'b1;
						res_a  = mk_res(srtb_pkg::KIND_BYTE, pair_b, 16'd0);
					end
				end
				phase_d = (pnext == len_q) ? PH_TERM : PH_BODY_HI;
			end
			PH_TERM: begin
				phase_d  = PH_START;
				complete = 1'b1;
			end
			default: begin
				if (char_code != srtb_pkg::CH_S)
					err = 1'b1;
				phase_d = PH_TYPE;
			end
		endcase

		ent = '0;
		if (err || end_of_file) begin
			ent.count      = 2'd1;
			ent.first      = mk_res((complete && !err) ? srtb_pkg::KIND_DONE :
				srtb_pkg::KIND_FMT_ERR, 8'd0, 16'd0);
			halted_d       = 1'b1;
		end else if (have_a && have_b) begin
			ent.count  = 2'd2;
			ent.first  = res_a;
			ent.second = res_b;
		end else if (have_a) begin
			ent.count = 2'd1;
			ent.first = res_a;
		end else if (have_b) begin
			ent.count = 2'd1;
			ent.first = res_b;
		end
	end

	assign push       = accept && !halted_q && (ent.count != 2'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_prefix_on_q  <= 1'b0;
			address_prefix_on_q <= 1'b0;
			fill_gaps_on_q      <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == srtb_pkg::CFG_LENGTH_PREFIX)
				length_prefix_on_q <= cfg_data;
			if (cfg_index == srtb_pkg::CFG_ADDRESS_PREFIX)
				address_prefix_on_q <= cfg_data;
			if (cfg_index == srtb_pkg::CFG_FILL_GAPS)
				fill_gaps_on_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			first_q  <= '0;
			rtype_q  <= RT_S0;
			len_q    <= '0;
			pcnt_q   <= '0;
			hi_q     <= '0;
			exp_q    <= '0;
			seen_q   <= 1'b0;
			halted_q <= 1'b0;
		end else if (accept && !halted_q) begin
			phase_q  <= phase_d;
			first_q  <= first_d;
			rtype_q  <= rtype_d;
			len_q    <= len_d;
			pcnt_q   <= pcnt_d;
			hi_q     <= hi_d;
			exp_q    <= exp_d;
			seen_q   <= seen_d;
			halted_q <= halted_d;
		end
	end

	`SRTB_ASSERT_IMPL(a_no_push_halted, clk, arst_n, halted_q, !push)
	`SRTB_ASSERT_IMPL(a_halt_sticky, clk, arst_n, $past(halted_q), halted_q)

endmodule

`default_nettype wire

// File: rtl/core/srtb_queue.sv
`default_nettype none
`include "srecord_to_binary_converter_macros.svh"

module srtb_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire srtb_pkg::entry_t  push_entry,
	input  wire logic              pop,
	output srtb_pkg::entry_t       head,
	output logic                   head_valid,
	output logic                   full
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	srtb_pkg::entry_t   slots [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	`SRTB_ASSERT(a_no_overflow, clk, arst_n, !(push && full))
	`SRTB_ASSERT(a_no_underflow, clk, arst_n, !(pop && !head_valid))

endmodule

`default_nettype wire

// File: rtl/core/srtb_back.sv
`default_nettype none
`include "srecord_to_binary_converter_macros.svh"

module srtb_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire srtb_pkg::entry_t head,
	input  wire logic         head_valid,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [2:0]        kind,
	output logic [7:0]        value,
	output logic [15:0]       run_length,
	output logic              last_of_run
);

	logic              out_valid_q, sel_q, last_q;
	srtb_pkg::result_t res_q, cur;
	logic              load, last;

	// sel_q set: first result of the head entry already went out
	assign cur  = sel_q ? head.second : head.first;
	assign last = sel_q || (head.count == 2'd1);
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall)
				out_valid_q <= head_valid;
			if (load)
				sel_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= cur;
			last_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign value       = res_q.value;
	assign run_length  = res_q.run_length;
	assign last_of_run = last_q;

	`SRTB_ASSERT_IMPL(a_sel_holds_head, clk, arst_n, sel_q, head_valid && head.count == 2'd2)
	`SRTB_ASSERT_IMPL(a_run_nonzero, clk, arst_n,
		out_valid_q && res_q.kind == srtb_pkg::KIND_ZERO_RUN, res_q.run_length != 16'd0)

endmodule

`default_nettype wire

// File: rtl/core/srecord_to_binary_converter.sv
// A character's results share one queue slot and then pass through the output register.
// Throughput: one character per cycle while the queue has room (in_stall low);
// one result per cycle leaves the output register while out_stall is low.
// Reset (arst_n low) clears parser state, queue, output valid and all config registers.
`default_nettype none

module srecord_to_binary_converter #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [srtb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic                            cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            end_of_file,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [2:0]                           kind,
	output logic [7:0]                           value,
	output logic [15:0]                          run_length,
	output logic                                 last_of_run
);

	logic             full, push, pop, head_valid;
	srtb_pkg::entry_t push_entry, head;

	assign in_stall = full;

	srtb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_valid && !full),
		.char_code   (char_code),
		.end_of_file (end_of_file),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.push_entry  (push_entry)
	);

	srtb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	srtb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.value       (value),
		.run_length  (run_length),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam logic [7:0] CH_UPPER_A = 8'h41;

	typedef enum logic [2:0] {
		WAIT_S, WAIT_TYPE, LEN_HI_DIGIT, LEN_LO_DIGIT, SKIP_TERM, PAIR_HI_DIGIT, PAIR_LO_DIGIT
	} parse_phase_t;

	typedef enum logic [1:0] {REC_HEADER, REC_DATA, REC_END} record_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eof;
	} text_char_t;

	typedef struct packed {
		srtb_pkg::result_t res;
		logic              last;
	} emitted_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [srtb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic                           cfg_data = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [7:0]                     char_code = 8'h00;
	logic                           end_of_file = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [2:0]                     kind;
	logic [7:0]                     value;
	logic [15:0]                    run_length;
	logic                           last_of_run;

	// decoder model state
	parse_phase_t phase_q = WAIT_S;
	record_kind_t rec_kind = REC_HEADER;
	logic [7:0]   held_digit = 8'h00;
	logic [7:0]   rec_len = 8'h00;
	logic [7:0]   pairs_seen = 8'h00;
	logic [15:0]  load_addr = 16'h0000;
	logic [16:0]  next_addr = 17'h00000;
	logic         tracking_on = 1'b0;
	logic         decoder_stopped = 1'b0;
	logic         len_prefix_q = 1'b0;
	logic         addr_prefix_q = 1'b0;
	logic         fill_gaps_q = 1'b0;

	emitted_t   expected_results[$];
	text_char_t pending_chars[$];
	logic [7:0] record_chars[$];
	text_char_t next_char;
	emitted_t   want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int chars_sent = 0;
	int chars_queued = 0;
	int addr_cursor = 0;
	int mismatch_count = 0;
	int hold_left = 0;
	logic hold_armed = 1'b1;

	srecord_to_binary_converter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.value       (value),
		.run_length  (run_length),
		.last_of_run (last_of_run)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = c - srtb_pkg::CH_ZERO;
		if (c > srtb_pkg::CH_NINE)
			v = v - 8'd7;
		return v;
	endfunction

	// high digit is shifted out of range, low digit is not masked
	function automatic logic [7:0] byte_of(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] vh;
		vh = digit_value(hi);
		return {vh[3:0], 4'h0} | digit_value(lo);
	endfunction

	function automatic emitted_t make_result(input logic [2:0] k, input logic [7:0] b,
			input logic [15:0] run);
		emitted_t r;
		r.res.kind = k;
		r.res.value = b;
		r.res.run_length = run;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic eof);
		emitted_t    produced[$];
		logic        bad;
		logic        at_term;
		logic [7:0]  pair_byte;
		logic [7:0]  pair_no;
		logic [16:0] data_count;
		logic [16:0] gap;
		bad = 1'b0;
		at_term = 1'b0;
		if (decoder_stopped)
			return;
		case (phase_q)
		WAIT_TYPE: begin
			if (c == srtb_pkg::CH_ZERO)
				rec_kind = REC_HEADER;
			else if (c == srtb_pkg::CH_ONE)
				rec_kind = REC_DATA;
			else if (c == srtb_pkg::CH_NINE)
				rec_kind = REC_END;
			else
				bad = 1'b1;
			phase_q = LEN_HI_DIGIT;
		end
		LEN_HI_DIGIT: begin
			held_digit = c;
			phase_q = LEN_LO_DIGIT;
		end
		PAIR_HI_DIGIT: begin
			held_digit = c;
			phase_q = PAIR_LO_DIGIT;
		end
		LEN_LO_DIGIT: begin
			rec_len = byte_of(held_digit, c);
			pairs_seen = 8'h00;
			load_addr = 16'h0000;
			if (rec_kind == REC_DATA && len_prefix_q)
				produced.push_back(make_result(srtb_pkg::KIND_BYTE,
					addr_prefix_q ? rec_len : rec_len - 8'd2, 16'd0));
			phase_q = (rec_len == 8'd0) ? SKIP_TERM : PAIR_HI_DIGIT;
		end
		PAIR_LO_DIGIT: begin
			pair_byte = byte_of(held_digit, c);
			pair_no = pairs_seen + 8'd1;
			pairs_seen = pair_no;
			if (rec_kind == REC_DATA) begin
				if (pair_no == 8'd1) begin
					load_addr = {pair_byte, 8'h00};
					if (addr_prefix_q)
						produced.push_back(make_result(srtb_pkg::KIND_BYTE,
							pair_byte, 16'd0));
				end else if (pair_no == 8'd2) begin
					data_count = (rec_len >= 8'd3) ? {9'd0, rec_len - 8'd3} : 17'd0;
					load_addr[7:0] = pair_byte;
					if (addr_prefix_q)
						produced.push_back(make_result(srtb_pkg::KIND_BYTE,
							pair_byte, 16'd0));
					if (fill_gaps_q) begin
						if (!tracking_on) begin
							tracking_on = 1'b1;
							next_addr = {1'b0, load_addr} + data_count;
						end else if (next_addr > {1'b0, load_addr}) begin
							produced.push_back(make_result(srtb_pkg::KIND_OVERLAP,
								8'd0, 16'd0));
							decoder_stopped = 1'b1;
						end else begin
							gap = {1'b0, load_addr} - next_addr;
							if (gap != 17'd0)
								produced.push_back(make_result(srtb_pkg::KIND_ZERO_RUN,
									8'd0, gap[15:0]));
							next_addr = {1'b0, load_addr} + data_count;
						end
					end
				end else if (pair_no < rec_len) begin
					produced.push_back(make_result(srtb_pkg::KIND_BYTE, pair_byte, 16'd0));
				end
			end
			phase_q = (pair_no == rec_len) ? SKIP_TERM : PAIR_HI_DIGIT;
		end
		SKIP_TERM: begin
			phase_q = WAIT_S;
			at_term = 1'b1;
		end
		default: begin
			if (c != srtb_pkg::CH_S)
				bad = 1'b1;
			phase_q = WAIT_TYPE;
		end
		endcase

		// an error or end of file replaces whatever this character produced
		if (bad) begin
			produced.delete();
			produced.push_back(make_result(srtb_pkg::KIND_FMT_ERR, 8'd0, 16'd0));
			decoder_stopped = 1'b1;
		end else if (eof) begin
			produced.delete();
			produced.push_back(make_result(at_term ? srtb_pkg::KIND_DONE :
				srtb_pkg::KIND_FMT_ERR, 8'd0, 16'd0));
			decoder_stopped = 1'b1;
		end
		foreach (produced[i]) begin
			produced[i].last = (i == produced.size() - 1);
			expected_results.push_back(produced[i]);
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_char(char_code, end_of_file);
				chars_sent <= chars_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_char = pending_chars.pop_front();
					in_valid <= 1'b1;
					char_code <= next_char.ch;
					end_of_file <= next_char.eof;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver; one long hold once traffic is flowing so the block backs up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_armed && out_valid && chars_sent >= 300) begin
			hold_armed <= 1'b0;
			hold_left <= 120;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result kind=%0d value=%02h run=%0d last=%0b",
						$time, kind, value, run_length, last_of_run);
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.res.kind || value !== want.res.value ||
						run_length !== want.res.run_length || last_of_run !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: exp %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
							$time, want.res.kind, want.res.value, want.res.run_length,
							want.last, kind, value, run_length, last_of_run);
				end
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? srtb_pkg::CH_ZERO + n : CH_UPPER_A + (n - 4'd10);
	endfunction

	task automatic add_pair(input logic [7:0] b, input logic noisy);
		if (noisy) begin
			record_chars.push_back(8'($urandom_range(255)));
			record_chars.push_back(8'($urandom_range(255)));
		end else begin
			record_chars.push_back(hex_char(b[7:4]));
			record_chars.push_back(hex_char(b[3:0]));
		end
	endtask

	task automatic build_record(input logic [7:0] type_ch, input logic [7:0] ll,
			input logic [15:0] addr);
		int i;
		record_chars.delete();
		record_chars.push_back(srtb_pkg::CH_S);
		record_chars.push_back(type_ch);
		add_pair(ll, 1'b0);
		for (i = 1; i <= ll; i++) begin
			if (type_ch == srtb_pkg::CH_ONE && i == 1)
				add_pair(addr[15:8], 1'b0);
			else if (type_ch == srtb_pkg::CH_ONE && i == 2)
				add_pair(addr[7:0], 1'b0);
			else
				add_pair(8'($urandom_range(255)), $urandom_range(99) < 10);
		end
		record_chars.push_back(8'($urandom_range(255)));
	endtask

	task automatic push_char(input logic [7:0] ch, input logic eof);
		text_char_t tc;
		tc.ch = ch;
		tc.eof = eof;
		pending_chars.push_back(tc);
		chars_queued++;
	endtask

	// eof_at < 0: whole record, no end of file
	task automatic queue_record(input int eof_at);
		int i;
		for (i = 0; i < record_chars.size(); i++) begin
			if (eof_at >= 0 && i > eof_at)
				break;
			push_char(record_chars[i], i == eof_at);
		end
	endtask

	// addresses only move forward so gap tracking never sees an overlap
	task automatic add_data_record(input logic [7:0] ll);
		int gap_pick;
		int addr;
		gap_pick = ($urandom_range(99) < 40) ? 0 : int'($urandom_range(1, 40));
		addr = addr_cursor + gap_pick;
		if (ll >= 8'd2)
			addr_cursor = addr + ((ll >= 8'd3) ? ll - 3 : 0);
		build_record(srtb_pkg::CH_ONE, ll, addr[15:0]);
		queue_record(-1);
	endtask

	task automatic add_random_record();
		int pick;
		logic [7:0] ll;
		pick = $urandom_range(99);
		ll = ($urandom_range(99) < 90) ? 8'($urandom_range(24)) : 8'($urandom_range(25, 80));
		if (pick < 10) begin
			build_record(srtb_pkg::CH_ZERO, ll, 16'h0000);
			queue_record(-1);
		end else if (pick < 20) begin
			build_record(srtb_pkg::CH_NINE, ll, 16'h0000);
			queue_record(-1);
		end else begin
			add_data_record(ll);
		end
	endtask

	task automatic write_cfg(input logic [srtb_pkg::CFG_IDX_W-1:0] idx, input logic bit_val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bit_val;
		case (idx)
		srtb_pkg::CFG_LENGTH_PREFIX:  len_prefix_q = bit_val;
		srtb_pkg::CFG_ADDRESS_PREFIX: addr_prefix_q = bit_val;
		srtb_pkg::CFG_FILL_GAPS:      fill_gaps_q = bit_val;
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [2:0] settings;
		logic [7:0] odd_ch;
		int phase;
		int phase_start;
		int jump_addr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (phase = 0; phase < 8; phase++) begin
			if (phase < 3) begin
				send_idle_pct = 21;
				recv_idle_pct = 45;
			end else if (phase < 6) begin
				send_idle_pct = 45;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
			0:       settings = 3'b000;
			1, 7:    settings = 3'b111;
			2:       settings = 3'b101;
			default: settings = 3'($urandom_range(7));
			endcase
			write_cfg(srtb_pkg::CFG_LENGTH_PREFIX, settings[0]);
			write_cfg(srtb_pkg::CFG_ADDRESS_PREFIX, settings[1]);
			write_cfg(srtb_pkg::CFG_FILL_GAPS, settings[2]);
			phase_start = chars_queued;

			// empty header/end records and the short data records
			if (phase == 1) begin
				build_record(srtb_pkg::CH_ZERO, 8'd0, 16'h0000);
				record_chars[record_chars.size() - 1] = 8'h00;
				queue_record(-1);
			end
			if (phase == 1 || phase == 2) begin
				add_data_record(8'd0);
				add_data_record(8'd1);
			end
			if (phase == 1) begin
				build_record(srtb_pkg::CH_NINE, 8'd0, 16'h0000);
				record_chars[record_chars.size() - 1] = 8'hFF;
				queue_record(-1);
			end
			if (phase == 4)
				add_data_record(8'd255);
			while (chars_queued - phase_start < 20)
				add_random_record();
			wait_drained();
		end

		// far jump: zero run long enough to set its top bits
		jump_addr = int'($urandom_range(addr_cursor + 32768, 16'hFF00));
		build_record(srtb_pkg::CH_ONE, 8'd5, jump_addr[15:0]);
		queue_record(-1);
		addr_cursor = jump_addr + 2;

		case ($urandom_range(4))
		0: begin
			build_record(srtb_pkg::CH_NINE, 8'($urandom_range(4)), 16'h0000);
			queue_record(record_chars.size() - 1);
		end
		1: begin
			build_record(srtb_pkg::CH_ONE, 8'd5, 16'($urandom_range(addr_cursor - 1)));
			queue_record(record_chars.size() - 1);
		end
		2: begin
			build_record(srtb_pkg::CH_ONE, 8'($urandom_range(3, 12)), addr_cursor[15:0]);
			queue_record(int'($urandom_range(record_chars.size() - 2)));
		end
		3: begin
			do
				odd_ch = 8'($urandom_range(255));
			while (odd_ch == srtb_pkg::CH_S);
			push_char(odd_ch, 1'($urandom_range(1)));
		end
		default: begin
			do
				odd_ch = 8'($urandom_range(255));
			while (odd_ch inside {srtb_pkg::CH_ZERO, srtb_pkg::CH_ONE, srtb_pkg::CH_NINE});
			push_char(srtb_pkg::CH_S, 1'b0);
			push_char(odd_ch, 1'($urandom_range(1)));
		end
		endcase
		// decoder has stopped by now; these must produce nothing
		add_random_record();
		add_random_record();

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: srecord_to_binary_converter.f
+incdir+rtl/core
rtl/core/srtb_pkg.sv
rtl/core/srtb_front.sv
rtl/core/srtb_queue.sv
rtl/core/srtb_back.sv
rtl/core/srecord_to_binary_converter.sv
tb/tb_top.sv
